// ----- hw/rtl/arpc_pkg.sv -----
package arpc_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int Q_DEPTH = 2;

    localparam logic [1:0] MODE_RESOLVE = 2'd0;
    localparam logic [1:0] MODE_REPLY   = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic [1:0] ST_SEND     = 2'd0;
    localparam logic [1:0] ST_RESOLVED = 2'd1;
    localparam logic [1:0] ST_NOANSWER = 2'd2;
    localparam logic [1:0] ST_BUSY     = 2'd3;

    localparam logic [15:0] OPCODE_REPLY = 16'd2;

    localparam logic [1:0] CFG_LOCAL_IP  = 2'd0;
    localparam logic [1:0] CFG_LOCAL_MAC = 2'd1;
    localparam logic [1:0] CFG_LIFETIME  = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd3;

    localparam logic [31:0] LIFETIME_RESET = 32'd60000;
    localparam logic [31:0] TIMEOUT_RESET  = 32'd16000;

    typedef enum logic [1:0] {
        OP_RESOLVE,
        OP_REPLY,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] ip;
        logic [47:0] mac;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] ip;
        logic [47:0] mac;
        logic        from_cache;
        logic        cache_full;
    } res_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_TICK,
        BK_OUT
    } bk_state_t;

endpackage

// ----- hw/rtl/arpc_front.sv -----
module arpc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_mode,
    input  logic [31:0]          in_ip,
    input  logic [47:0]          in_mac,
    input  logic [15:0]          in_opcode,
    output logic                 q_valid,
    input  logic                 q_ready,
    output arpc_pkg::cmd_t       q_cmd
);

    arpc_pkg::cmd_t q_reg [arpc_pkg::Q_DEPTH];
    logic           wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           keep;
    logic           push, pop;
    arpc_pkg::cmd_t cmd;

    always_comb begin
        cmd.ip  = in_ip;
        cmd.mac = in_mac;
        keep    = 1'b1;
        cmd.op  = arpc_pkg::OP_TICK;
        unique case (in_mode)
            arpc_pkg::MODE_RESOLVE: cmd.op = arpc_pkg::OP_RESOLVE;
            arpc_pkg::MODE_REPLY: begin
                cmd.op = arpc_pkg::OP_REPLY;
                keep   = (in_opcode == arpc_pkg::OPCODE_REPLY);
            end
            arpc_pkg::MODE_TICK: cmd.op = arpc_pkg::OP_TICK;
            default: keep = 1'b0;
        endcase
    end

    assign in_ready = (cnt_reg != 2'(arpc_pkg::Q_DEPTH));
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = q_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) q_reg[wp_reg] <= cmd;
    end

endmodule

// ----- hw/rtl/arpc_back.sv -----
module arpc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  arpc_pkg::cmd_t       q_cmd,
    input  logic [31:0]          lifetime,
    input  logic [31:0]          timeout,
    output logic                 busy,
    output logic                 res_valid,
    input  logic                 res_ready,
    output arpc_pkg::res_t       res
);

    localparam int N = arpc_pkg::SLOT_COUNT;
    localparam int W = arpc_pkg::IDX_W;
    localparam int C = arpc_pkg::CNT_W;

    logic [31:0] e_ip_reg    [N];
    logic [47:0] e_mac_reg   [N];
    logic [31:0] e_stamp_reg [N];
    logic [N-1:0] e_val_reg, e_val_next;

    arpc_pkg::bk_state_t st_reg, st_next;
    arpc_pkg::cmd_t      cmd_reg, cmd_next;
    arpc_pkg::res_t      res_reg, res_next;
    logic [C-1:0]        k_reg, k_next;
    logic [31:0]         tick_reg, tick_next;
    logic [31:0]         wait_reg, wait_next;
    logic [31:0]         pip_reg, pip_next;
    logic                pend_reg, pend_next, sec_reg, sec_next;
    logic                wr;
    logic [W-1:0]        ki;
    logic                live;
    logic [31:0]         age, wait_inc;

    assign ki       = k_reg[W-1:0];
    assign age      = tick_reg - e_stamp_reg[ki];
    assign live     = e_val_reg[ki] && (age < lifetime);
    assign q_ready  = (st_reg == arpc_pkg::BK_IDLE);
    assign res_valid = (st_reg == arpc_pkg::BK_OUT);
    assign res      = res_reg;
    assign busy     = (st_reg != arpc_pkg::BK_IDLE);
    assign wait_inc = (wait_reg == 32'hFFFF_FFFF) ? wait_reg : wait_reg + 32'd1;

    always_comb begin
        st_next    = st_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        k_next     = k_reg;
        tick_next  = tick_reg;
        wait_next  = wait_reg;
        pip_next   = pip_reg;
        pend_next  = pend_reg;
        sec_next   = sec_reg;
        e_val_next = e_val_reg;
        wr         = 1'b0;
        unique case (st_reg)
            arpc_pkg::BK_IDLE: begin
                if (q_valid) begin
                    cmd_next = q_cmd;
                    k_next   = '0;
                    res_next = '{status: arpc_pkg::ST_BUSY, ip: q_cmd.ip, mac: '0,
                                 from_cache: 1'b0, cache_full: 1'b0};
                    unique case (q_cmd.op)
                        arpc_pkg::OP_RESOLVE: begin
                            if (pend_reg) st_next = arpc_pkg::BK_OUT;
                            else st_next = arpc_pkg::BK_SCAN;
                        end
                        arpc_pkg::OP_REPLY: begin
                            if (pend_reg && q_cmd.ip == pip_reg) begin
                                pend_next = 1'b0;
                                sec_next  = 1'b0;
                                wait_next = '0;
                                st_next   = arpc_pkg::BK_SCAN;
                            end
                        end
                        default: begin
                            tick_next = tick_reg + 32'd1;
                            st_next   = arpc_pkg::BK_TICK;
                        end
                    endcase
                end
            end
            arpc_pkg::BK_SCAN: begin
                if (cmd_reg.op == arpc_pkg::OP_RESOLVE) begin
                    if (k_reg == C'(N)) begin
                        pend_next = 1'b1;
                        sec_next  = 1'b0;
                        wait_next = '0;
                        pip_next  = cmd_reg.ip;
                        res_next.status = arpc_pkg::ST_SEND;
                        st_next = arpc_pkg::BK_OUT;
                    end else if (live && e_ip_reg[ki] == cmd_reg.ip) begin
                        res_next.status     = arpc_pkg::ST_RESOLVED;
                        res_next.mac        = e_mac_reg[ki];
                        res_next.from_cache = 1'b1;
                        st_next = arpc_pkg::BK_OUT;
                    end else begin
                        k_next = k_reg + C'(1);
                    end
                end else begin
                    res_next.status = arpc_pkg::ST_RESOLVED;
                    res_next.mac    = cmd_reg.mac;
                    if (k_reg == C'(N)) begin
                        res_next.cache_full = 1'b1;
                        st_next = arpc_pkg::BK_OUT;
                    end else if (!live) begin
                        wr = 1'b1;
                        e_val_next[ki] = 1'b1;
                        st_next = arpc_pkg::BK_OUT;
                    end else begin
                        k_next = k_reg + C'(1);
                    end
                end
            end
            arpc_pkg::BK_TICK: begin
                if (k_reg == C'(N)) begin
                    st_next = arpc_pkg::BK_IDLE;
                    if (pend_reg) begin
                        wait_next = wait_inc;
                        if (wait_inc >= timeout) begin
                            res_next.ip = pip_reg;
                            wait_next   = '0;
                            st_next     = arpc_pkg::BK_OUT;
                            if (!sec_reg) begin
                                sec_next = 1'b1;
                                res_next.status = arpc_pkg::ST_SEND;
                            end else begin
                                pend_next = 1'b0;
                                sec_next  = 1'b0;
                                res_next.status = arpc_pkg::ST_NOANSWER;
                            end
                        end
                    end
                end else begin
                    if (!live) e_val_next[ki] = 1'b0;
                    k_next = k_reg + C'(1);
                end
            end
            arpc_pkg::BK_OUT: begin
                if (res_ready) st_next = arpc_pkg::BK_IDLE;
            end
            default: st_next = arpc_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= arpc_pkg::BK_IDLE;
            e_val_reg <= '0;
            tick_reg  <= '0;
            wait_reg  <= '0;
            pip_reg   <= '0;
            pend_reg  <= 1'b0;
            sec_reg   <= 1'b0;
            k_reg     <= '0;
        end else begin
            st_reg    <= st_next;
            e_val_reg <= e_val_next;
            tick_reg  <= tick_next;
            wait_reg  <= wait_next;
            pip_reg   <= pip_next;
            pend_reg  <= pend_next;
            sec_reg   <= sec_next;
            k_reg     <= k_next;
        end
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        if (wr) begin
            e_ip_reg[ki]    <= cmd_reg.ip;
            e_mac_reg[ki]   <= cmd_reg.mac;
            e_stamp_reg[ki] <= tick_reg;
        end
    end

endmodule

// ----- hw/rtl/arp_cache_resolver.sv -----
// channel | dir | tdata (low bit up)                         | tuser
// s_      | in  | ip_address[31:0] sender_mac[79:32]          | mode[1:0]
//         |     | reply_opcode[95:80]                         |
// m_      | out | result_ip[31:0] result_mac[79:32]           | status[1:0]
//         |     | from_cache[80] cache_full[81], pad to 88    |
// cfg_    | in  | cfg_wdata[31:0] to lifetime or timeout     | -
// A resolve, or a reply that answers the pending request, runs the one-slot-a-cycle
// cache scan; a resolve while a request is pending returns busy with no scan, other
// replies are dropped, and a tick runs the aging sweep and sends a result when a wait runs out.
// A two-entry request queue lets input be taken while the back end works
// or a result waits on m_axis_tready. Reset is synchronous; cache valid bits clear at once.
module arp_cache_resolver (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // ip_address, sender_mac, reply_opcode
    input  logic [1:0]   s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [87:0]  m_axis_tdata,  // result_ip, result_mac, from_cache, cache_full
    output logic [1:0]   m_axis_tuser,  // status
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [47:0]  cfg_wdata
);

    logic [31:0]    lifetime_reg, timeout_reg;
    logic           q_valid, q_ready, busy;
    arpc_pkg::cmd_t q_cmd;
    arpc_pkg::res_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lifetime_reg <= arpc_pkg::LIFETIME_RESET;
            timeout_reg  <= arpc_pkg::TIMEOUT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                arpc_pkg::CFG_LIFETIME: lifetime_reg <= cfg_wdata[31:0];
                arpc_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    arpc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_mode(s_axis_tuser), .in_ip(s_axis_tdata[31:0]),
        .in_mac(s_axis_tdata[79:32]), .in_opcode(s_axis_tdata[95:80]),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    arpc_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .lifetime(lifetime_reg), .timeout(timeout_reg), .busy(busy),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {6'd0, res.cache_full, res.from_cache, res.mac, res.ip};

    a_q_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> !busy) else $error("queue popped while busy");
    a_out_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> busy) else $error("result without work");
    a_mac_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != arpc_pkg::ST_RESOLVED) |-> (res.mac == 48'd0))
        else $error("mac not zero");
    a_fc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && res.from_cache) |-> !res.cache_full) else $error("flag clash");

endmodule
